// ----- hw/rtl/tspd_pkg.sv -----
// ----------------------------------------------------------------------------
// tspd_pkg
// Types and constants shared by the thermometer packet row decoder.
// ----------------------------------------------------------------------------
package tspd_pkg;

   localparam int unsigned REQ_DATA_W = 80;
   localparam int unsigned RSP_DATA_W = 64;
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 6;

   localparam logic [6:0] LEN_SHORT     = 7'd50;
   localparam logic [6:0] LEN_LONG      = 7'd54;
   localparam logic [2:0] TYPE_DATETIME = 3'd5;

   localparam logic [5:0] MIN_ROWS_RST  = 6'd2;
   localparam logic [5:0] MAX_ROWS_RST  = 6'd10;

   typedef enum logic [2:0] {
      ST_LENGTH   = 3'd0,
      ST_CHECKSUM = 3'd1,
      ST_TEMP     = 3'd2,
      ST_DATETIME = 3'd3,
      ST_SKIPPED  = 3'd4
   } status_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MIN_ROWS         = 2'd0,
      CSR_MAX_ROWS         = 2'd1,
      CSR_STOP_AFTER_FIRST = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [5:0] min_rows;
      logic [5:0] max_rows;
      logic       stop_after_first;
   } cfg_type;

   // packed MSB first, so sensor_id lands in the lowest bits
   typedef struct packed {
      logic [5:0]        second_value;
      logic [5:0]        minute_value;
      logic [4:0]        hour_value;
      logic [4:0]        day_value;
      logic [3:0]        month_value;
      logic [6:0]        year_offset;
      logic              summer_time;
      logic signed [11:0] temp_tenths;
      logic              low_batt;
      logic [3:0]        channel_number;
      logic [7:0]        sensor_id;
   } result_type;

   localparam int unsigned RESULT_W = $bits(result_type);

endpackage

// ----- hw/rtl/thermo_sensor_packet_decoder.sv -----
// ----------------------------------------------------------------------------
// thermo_sensor_packet_decoder
// Each row passes the input register, then the decode, then the result register.
// Throughput: one row per cycle unless rsp_tready holds the output back; the
// message state updates in the same cycle as the result register loads.
// Reset: synchronous; clears both pipeline valids, the message state and
// loads the configuration defaults (2, 10, stop after first on).
// ----------------------------------------------------------------------------
module thermo_sensor_packet_decoder
   import tspd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // row_data[63:0], row_length[70:64], row_count[76:71], zero[79:77]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // sensor_id, channel_number, low_batt, temp_tenths, summer_time,
   // year_offset, month_value, day_value, hour_value, minute_value,
   // second_value, zero[63:59]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // status
   output logic [2:0]            rsp_tuser,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg;
   status_type dec_status;
   result_type dec_result;

   logic        s1_valid_ff, s1_valid_in;
   logic [63:0] s1_row_ff,   s1_row_in;
   logic [6:0]  s1_len_ff,   s1_len_in;
   logic [5:0]  s1_cnt_ff,   s1_cnt_in;
   logic        s1_last_ff,  s1_last_in;
   logic        msg_ff,      msg_in;
   logic        rsp_valid_ff, rsp_valid_in;
   status_type  rsp_status_ff, rsp_status_in;
   result_type  rsp_result_ff, rsp_result_in;

   logic out_ready;
   logic s1_fire;
   logic dec_ok;

   tspd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tspd_decode u_decode (
      .row_data        (s1_row_ff),
      .row_length      (s1_len_ff),
      .row_count       (s1_cnt_ff),
      .cfg             (cfg),
      .message_decoded (msg_ff),
      .status          (dec_status),
      .result          (dec_result)
   );

   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && out_ready;
   assign req_tready = !s1_valid_ff || out_ready;
   assign dec_ok     = (dec_status == ST_TEMP) || (dec_status == ST_DATETIME);

   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_row_in     = s1_row_ff;
      s1_len_in     = s1_len_ff;
      s1_cnt_in     = s1_cnt_ff;
      s1_last_in    = s1_last_ff;
      msg_in        = msg_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_result_in = rsp_result_ff;
      if (req_tready) begin
         s1_valid_in = req_tvalid;
         s1_row_in   = req_tdata[63:0];
         s1_len_in   = req_tdata[70:64];
         s1_cnt_in   = req_tdata[76:71];
         s1_last_in  = req_tlast;
      end
      if (out_ready) begin
         rsp_valid_in = s1_valid_ff;
      end
      if (s1_fire) begin
         rsp_status_in = dec_status;
         rsp_result_in = dec_result;
         if (s1_last_ff) begin
            msg_in = 1'b0;
         end else if (dec_ok) begin
            msg_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         msg_ff       <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         msg_ff       <= msg_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_row_ff     <= s1_row_in;
      s1_len_ff     <= s1_len_in;
      s1_cnt_ff     <= s1_cnt_in;
      s1_last_ff    <= s1_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RESULT_W){1'b0}}, rsp_result_ff};

   a_msg_set : assert property (@(posedge clock) disable iff (reset)
      (s1_fire && dec_ok && !s1_last_ff) |=> msg_ff)
      else $error("message state not set after a decoded row");

   a_msg_clr : assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_last_ff) |=> !msg_ff)
      else $error("message state not cleared after last row");

   a_empty_window : assert property (@(posedge clock) disable iff (reset)
      (s1_fire && (cfg.min_rows > cfg.max_rows)) |-> (dec_status == ST_SKIPPED))
      else $error("row decoded with an empty row window");

   a_fields_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == ST_LENGTH || rsp_tuser == ST_CHECKSUM ||
                      rsp_tuser == ST_SKIPPED)) |-> (rsp_tdata == '0))
      else $error("non-zero fields on a failed or skipped row");

endmodule

// ----- hw/rtl/tspd_csr.sv -----
// ----------------------------------------------------------------------------
// tspd_csr
// Configuration registers: row count window and stop-after-first mode.
// ----------------------------------------------------------------------------
module tspd_csr
   import tspd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_MIN_ROWS:         cfg_in.min_rows         = csr_wdata[5:0];
            CSR_MAX_ROWS:         cfg_in.max_rows         = csr_wdata[5:0];
            CSR_STOP_AFTER_FIRST: cfg_in.stop_after_first = csr_wdata[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_rows         <= MIN_ROWS_RST;
         cfg_ff.max_rows         <= MAX_ROWS_RST;
         cfg_ff.stop_after_first <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hw/rtl/tspd_decode.sv -----
// ----------------------------------------------------------------------------
// tspd_decode
// Row admission, length and nibble checksum test, field extraction.
// ----------------------------------------------------------------------------
module tspd_decode
   import tspd_pkg::*;
(
   input  logic [63:0] row_data,
   input  logic [6:0]  row_length,
   input  logic [5:0]  row_count,
   input  cfg_type     cfg,
   input  logic        message_decoded,
   output status_type  status,
   output result_type  result
);

   logic [7:0] pkt_b [6];
   logic [7:0] nib_sum;
   logic       admit;
   logic       len_ok;

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         pkt_b[i] = row_data[61 - 8*i -: 8];
      end
      nib_sum = '0;
      for (int i = 1; i < 6; i++) begin
         nib_sum = nib_sum + {4'd0, pkt_b[i][7:4]} + {4'd0, pkt_b[i][3:0]};
      end
      admit  = (row_count >= cfg.min_rows) && (row_count <= cfg.max_rows) &&
               !(cfg.stop_after_first && message_decoded);
      len_ok = (row_length == LEN_SHORT) || (row_length == LEN_LONG);

      result = '0;
      if (!admit) begin
         status = ST_SKIPPED;
      end else if (!len_ok) begin
         status = ST_LENGTH;
      end else if (nib_sum[5:0] != pkt_b[0][5:0]) begin
         status = ST_CHECKSUM;
      end else if (pkt_b[2][6:4] == TYPE_DATETIME) begin
         status              = ST_DATETIME;
         result.summer_time  = pkt_b[1][7];
         result.year_offset  = pkt_b[1][6:0];
         result.month_value  = pkt_b[2][3:0];
         result.day_value    = pkt_b[3][7:3];
         result.hour_value   = {pkt_b[3][2:0], pkt_b[4][7:6]};
         result.minute_value = pkt_b[4][5:0];
         result.second_value = pkt_b[5][6:1];
      end else begin
         status                = ST_TEMP;
         result.sensor_id      = pkt_b[1];
         result.channel_number = {1'b0, pkt_b[2][2:0]} + 4'd1;
         result.low_batt       = pkt_b[2][3];
         result.temp_tenths    = {pkt_b[3][3:0], pkt_b[4]};
      end
   end

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the thermometer packet row decoder. Rows go in on
// the req stream and one status/result transaction per row is compared with a
// local model of the row window, the stop-after-first logic and the field
// decode. A directed set of rows opens the run. Random messages of repeated
// packets, with corrupt, mis-sized and noise rows mixed in, follow under
// several row-window settings, with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import tspd_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 500000;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [2:0]            rsp_tuser;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   bit                    calm       = 1'b0;
   int unsigned           cycles     = 0;
   int unsigned           rows_sent  = 0;

   class row_outcome_board;
      typedef struct {
         status_type status;
         result_type fields;
      } outcome_type;

      outcome_type pending_outcomes[$];
      logic [5:0]  min_rows         = MIN_ROWS_RST;
      logic [5:0]  max_rows         = MAX_ROWS_RST;
      logic        stop_after_first = 1'b1;
      logic        message_decoded  = 1'b0;
      int unsigned errors           = 0;

      function void set_register(csr_index_type idx, logic [5:0] value);
         case (idx)
            CSR_MIN_ROWS:         min_rows = value;
            CSR_MAX_ROWS:         max_rows = value;
            CSR_STOP_AFTER_FIRST: stop_after_first = value[0];
            default: ;
         endcase
      endfunction

      function int pending();
         return pending_outcomes.size();
      endfunction

      function void note_row(logic [63:0] row, logic [6:0] len, logic [5:0] cnt,
                             logic last);
         outcome_type o;
         logic [7:0]  b [6];
         logic [5:0]  sum;
         o.status = ST_SKIPPED;
         o.fields = '0;
         if (cnt >= min_rows && cnt <= max_rows
             && !(stop_after_first && message_decoded)) begin
            // packet bytes start at row bit 61, just under the two top bits
            for (int i = 0; i < 6; i++) b[i] = row[61-8*i -: 8];
            sum = '0;
            for (int i = 1; i < 6; i++) sum = sum + b[i][7:4] + b[i][3:0];
            if (len != LEN_SHORT && len != LEN_LONG) begin
               o.status = ST_LENGTH;
            end else if (sum != b[0][5:0]) begin
               o.status = ST_CHECKSUM;
            end else if (b[2][6:4] == TYPE_DATETIME) begin
               o.status                = ST_DATETIME;
               o.fields.summer_time    = b[1][7];
               o.fields.year_offset    = b[1][6:0];
               o.fields.month_value    = b[2][3:0];
               o.fields.day_value      = b[3][7:3];
               o.fields.hour_value     = {b[3][2:0], b[4][7:6]};
               o.fields.minute_value   = b[4][5:0];
               o.fields.second_value   = b[5][6:1];
            end else begin
               o.status                = ST_TEMP;
               o.fields.sensor_id      = b[1];
               o.fields.channel_number = {1'b0, b[2][2:0]} + 4'd1;
               o.fields.low_batt       = b[2][3];
               o.fields.temp_tenths    = {b[3][3:0], b[4]};
            end
            if (o.status == ST_TEMP || o.status == ST_DATETIME) message_decoded = 1'b1;
         end
         if (last) message_decoded = 1'b0;
         pending_outcomes.push_back(o);
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 40) $display("[%0t] mismatch: %s", $time, msg);
      endtask

      task compare_field(string name, longint unsigned got, longint unsigned want);
         if (got != want) report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
      endtask

      task check_result(logic [2:0] status, logic [RSP_DATA_W-1:0] data);
         outcome_type o;
         result_type  r;
         if (pending_outcomes.size() == 0) begin
            report($sformatf("result transaction with no row outstanding, status %0d",
                             status));
            return;
         end
         o = pending_outcomes.pop_front();
         r = data[RESULT_W-1:0];
         compare_field("status", status, o.status);
         compare_field("sensor_id", r.sensor_id, o.fields.sensor_id);
         compare_field("channel_number", r.channel_number, o.fields.channel_number);
         compare_field("low_batt", r.low_batt, o.fields.low_batt);
         compare_field("temp_tenths", r.temp_tenths, o.fields.temp_tenths);
         compare_field("summer_time", r.summer_time, o.fields.summer_time);
         compare_field("year_offset", r.year_offset, o.fields.year_offset);
         compare_field("month_value", r.month_value, o.fields.month_value);
         compare_field("day_value", r.day_value, o.fields.day_value);
         compare_field("hour_value", r.hour_value, o.fields.hour_value);
         compare_field("minute_value", r.minute_value, o.fields.minute_value);
         compare_field("second_value", r.second_value, o.fields.second_value);
         compare_field("padding", data[RSP_DATA_W-1:RESULT_W], 0);
      endtask
   endclass

   row_outcome_board board = new();

   thermo_sensor_packet_decoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [63:0] build_row(logic [7:0] b1, logic [7:0] b2,
                                             logic [7:0] b3, logic [7:0] b4,
                                             logic [7:0] b5, logic [6:0] len, bit good);
      logic [5:0]  sum;
      logic [7:0]  b0;
      logic [63:0] row;
      sum = b1[7:4] + b1[3:0] + b2[7:4] + b2[3:0] + b3[7:4] + b3[3:0]
          + b4[7:4] + b4[3:0] + b5[7:4] + b5[3:0];
      b0 = {2'($urandom), sum};
      if (!good) b0[5:0] = sum ^ 6'($urandom_range(1, 63));
      row = {2'($urandom), b0, b1, b2, b3, b4, b5, 8'($urandom), 6'($urandom)};
      if (len == LEN_SHORT) row[13:0] = '0;
      else if (len == LEN_LONG) row[9:0] = '0;
      return row;
   endfunction

   function automatic logic [63:0] random_packet(bit datetime, logic [6:0] len, bit good);
      logic [7:0]  b2;
      int unsigned kind;
      b2 = 8'($urandom);
      if (datetime) begin
         b2[6:4] = TYPE_DATETIME;
      end else begin
         kind = $urandom_range(0, 6);
         if (3'(kind) >= TYPE_DATETIME) kind++;
         b2[6:4] = 3'(kind);
      end
      return build_row(8'($urandom), b2, 8'($urandom), 8'($urandom), 8'($urandom),
                       len, good);
   endfunction

   function automatic logic [6:0] good_length();
      return ($urandom_range(0, 1) != 0) ? LEN_LONG : LEN_SHORT;
   endfunction

   function automatic logic [6:0] bad_length();
      logic [6:0] l;
      if ($urandom_range(0, 1) != 0) l = 7'($urandom);
      else l = LEN_SHORT - 7'd1 + 7'($urandom_range(0, 6));
      if (l == LEN_SHORT || l == LEN_LONG) l++;
      return l;
   endfunction

   task automatic send_row(logic [63:0] row, logic [6:0] len, logic [5:0] cnt, logic last);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, cnt, len, row};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      board.note_row(row, len, cnt, last);
      rows_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [5:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      board.set_register(idx, value);
      @(posedge clock);
   endtask

   task automatic configure(logic [5:0] lo, logic [5:0] hi, logic stop);
      drain();
      write_csr(CSR_MIN_ROWS, lo);
      write_csr(CSR_MAX_ROWS, hi);
      write_csr(CSR_STOP_AFTER_FIRST, {5'b0, stop});
   endtask

   task automatic directed_rows();
      logic [63:0] t_min, t_max, dt_max;
      // channel 8, battery low, most negative reading
      t_min  = build_row(8'hFF, 8'h7F, 8'h08, 8'h00, 8'h5A, LEN_SHORT, 1'b1);
      t_max  = build_row(8'h00, 8'h00, 8'hF7, 8'hFF, 8'h00, LEN_LONG, 1'b1);
      dt_max = build_row(8'hFF, 8'h5F, 8'hFF, 8'hFF, 8'hFF, LEN_LONG, 1'b1);
      send_row(t_min, LEN_SHORT, 6'd2, 1'b0);
      send_row(t_min, LEN_SHORT, 6'd2, 1'b1);
      send_row(dt_max, LEN_LONG, MAX_ROWS_RST, 1'b1);
      send_row(t_max, LEN_LONG, 6'd3, 1'b0);
      send_row(t_max, LEN_LONG, 6'd3, 1'b0);
      send_row(t_max, LEN_LONG, 6'd3, 1'b1);
      // failed rows do not count as decoded
      send_row(t_max, 7'd51, 6'd4, 1'b0);
      send_row(build_row(8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, LEN_SHORT, 1'b0),
               LEN_SHORT, 6'd4, 1'b0);
      send_row(build_row(8'h81, 8'hD3, 8'h5C, 8'h2B, 8'h7E, LEN_SHORT, 1'b1),
               LEN_SHORT, 6'd4, 1'b1);
      send_row(t_max, LEN_LONG, 6'd1, 1'b1);
      send_row(t_max, LEN_LONG, 6'd11, 1'b1);
      send_row('1, 7'd127, 6'd63, 1'b1);
      send_row('0, 7'd0, 6'd0, 1'b0);
      send_row('0, LEN_SHORT, 6'd5, 1'b1);
      send_row('1, LEN_LONG, 6'd5, 1'b1);
      send_row(t_max, 7'd0, 6'd2, 1'b1);
      send_row(t_max, 7'd49, 6'd2, 1'b1);
      send_row(t_max, 7'd55, 6'd2, 1'b1);
      send_row(build_row(8'h3C, 8'hE3, 8'h0A, 8'h55, 8'h00, LEN_SHORT, 1'b1),
               LEN_SHORT, 6'd2, 1'b1);
      drain();
   endtask

   task automatic send_message();
      logic [5:0]  cnt;
      logic [6:0]  plen, len;
      logic [63:0] packet, row;
      int unsigned nrows, pick;
      bit          dt, last;
      if (board.min_rows <= board.max_rows && $urandom_range(0, 9) < 8)
         cnt = 6'($urandom_range(board.min_rows, board.max_rows));
      else
         cnt = 6'($urandom);
      nrows  = (cnt >= 1 && cnt <= 8) ? cnt : $urandom_range(1, 8);
      dt     = ($urandom_range(0, 3) == 0);
      plen   = good_length();
      packet = random_packet(dt, plen, 1'b1);
      calm   = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < nrows; i++) begin
         pick = $urandom_range(0, 99);
         len  = plen;
         row  = packet;
         if (pick >= 88) begin
            len = 7'($urandom);
            row = {$urandom, $urandom};
         end else if (pick >= 80) begin
            len = bad_length();
            row = random_packet(dt, len, 1'b1);
         end else if (pick >= 70) begin
            row = random_packet(dt, len, 1'b0);
         end else if (pick >= 60) begin
            len = good_length();
            row = random_packet($urandom_range(0, 3) == 0, len, 1'b1);
         end
         last = (i == nrows - 1);
         if ($urandom_range(0, 19) == 0) last = ~last;
         send_row(row, len, cnt, last);
      end
   endtask

   // result side
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tuser, rsp_tdata);
         if (stall_left != 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   initial begin
      int unsigned target;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      directed_rows();
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: configure(6'd0, 6'd63, 1'b0);
            1: configure(6'd63, 6'd63, 1'b1);
            2: configure(6'd5, 6'd3, 1'b1);  // empty window
            3: configure(6'd0, 6'd0, 1'b0);
            4: configure(MIN_ROWS_RST, MAX_ROWS_RST, 1'b1);
            5: configure(6'd1, 6'd8, 1'b0);
            default: configure(6'($urandom_range(0, 8)), 6'($urandom_range(4, 63)),
                               1'($urandom));
         endcase
         target = rows_sent + ((phase == 2) ? 40 : 110);
         while (rows_sent < target) begin
            send_message();
            if ($urandom_range(0, 49) == 0) drain();
         end
      end
      calm = 1'b0;
      drain();
      repeat (6) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
